/* rtl/chtu_pkg.sv */
// Shared constants and types for the chained hash table unit.
// No dependencies.
package chtu_pkg;

  localparam int INIT_W     = 4;
  localparam int DENS_W     = 7;
  localparam int DENS_MAX   = 100;
  localparam int INIT_RESET = 4;
  localparam int DENS_RESET = 75;

  localparam logic CFG_INIT_BITS = 1'b0;
  localparam logic CFG_DENSITY   = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

endpackage

/* rtl/chtu_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module chtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/chtu_div.sv */
// Threshold scaler: divides by the density scale with a reciprocal multiply.
// Depends on chtu_pkg.
module chtu_div #(
  parameter int NUM_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  import chtu_pkg::*;

  localparam int SHIFT   = NUM_W + 8;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DENS_MAX - 1) / DENS_MAX;
  localparam int RECIP_W = SHIFT - 6;
  localparam int PROD_W  = NUM_W + RECIP_W;

  logic              busy_r;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  quo_r;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(num_r) * PROD_W'(RECIP_W'(RECIP));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      num_r  <= num;
    end else if (busy_r) begin
      quo_r  <= NUM_W'(prod >> SHIFT);
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

/* rtl/chained_hash_table_unit.sv */
// Flow: lookup/remove read the bucket head, then walk the chain one entry at a time;
// insert reads the head and links the new entry in front; a refused insert answers
// without a memory access. A growing insert then splits each old bucket in turn and runs
// the threshold scaler. Clear sweeps max(2^MAX_HASH_BITS, POOL_ENTRIES) addresses and then
// runs the scaler. One word in flight; set by the single-read memory walk. Reset (synchronous,
// rst_n low) runs the same sweep with in_ready low; configuration writes are taken throughout it.
module chained_hash_table_unit #(
  parameter int MAX_HASH_BITS = 10,
  parameter int POOL_ENTRIES  = 1024,
  parameter int KEY_BITS      = 64,
  parameter int VALUE_BITS    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind,
  input  logic [KEY_BITS-1:0]               in_key,
  input  logic [VALUE_BITS-1:0]             in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [VALUE_BITS-1:0]             out_found_value,
  output logic [VALUE_BITS-1:0]             out_freed_value,
  output logic                              out_resized,
  output logic [$clog2(POOL_ENTRIES+1)-1:0] out_entry_total,
  output logic [$clog2(POOL_ENTRIES+1)-1:0] out_cleared_count,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [chtu_pkg::DENS_W-1:0]       cfg_data
);
  import chtu_pkg::*;

  localparam int NB     = 1 << MAX_HASH_BITS;
  localparam int HB_W   = MAX_HASH_BITS;
  localparam int SLOT_W = $clog2(POOL_ENTRIES);
  localparam int PTR_W  = $clog2(POOL_ENTRIES + 1);
  localparam int CNT_W  = PTR_W;
  localparam int BITS_W = $clog2(MAX_HASH_BITS + 1);
  localparam int SWP_N  = (NB > POOL_ENTRIES) ? NB : POOL_ENTRIES;
  localparam int SWP_W  = $clog2(SWP_N);
  localparam int NUM_W  = MAX_HASH_BITS + DENS_W;
  localparam int THR_W  = MAX_HASH_BITS + 1;
  localparam int KV_W   = KEY_BITS + VALUE_BITS;
  localparam int CMP_W  = THR_W + CNT_W;
  localparam int RST_BITS = (INIT_RESET > MAX_HASH_BITS) ? MAX_HASH_BITS : INIT_RESET;
  localparam int RST_THR  = ((1 << RST_BITS) * DENS_RESET) / DENS_MAX;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

  typedef enum logic [3:0] {
    S_SWEEP, S_DIV_GO, S_DIV_WAIT, S_IDLE, S_HRD, S_HGET, S_CMP,
    S_G_HRD, S_G_HGET, S_G_MV, S_G_WA, S_G_WB, S_RESP
  } state_t;

  state_t                state_r;
  kind_t                 kind_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [PTR_W-1:0]      e_r, prev_r, ga_r, gb_r;
  logic [CNT_W-1:0]      count_r;
  logic [BITS_W-1:0]     cur_bits_r;
  logic [THR_W-1:0]      thr_r;
  logic [HB_W-1:0]       gi_r;
  logic [SWP_W-1:0]      swp_r;
  logic                  resp_r;
  logic [INIT_W-1:0]     init_cfg_r;
  logic [DENS_W-1:0]     dens_cfg_r;

  status_t               res_status_r;
  logic [VALUE_BITS-1:0] res_found_r, res_freed_r;
  logic                  res_resized_r;
  logic [CNT_W-1:0]      res_cleared_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [VALUE_BITS-1:0] out_found_r, out_freed_r;
  logic                  out_resized_r;
  logic [CNT_W-1:0]      out_total_r, out_cleared_r;

  logic                  head_we;
  logic [HB_W-1:0]       head_waddr, head_raddr;
  logic [PTR_W-1:0]      head_wdata, head_rdata;
  logic                  link_we;
  logic [SLOT_W-1:0]     link_waddr;
  logic [PTR_W-1:0]      link_wdata, link_rdata;
  logic                  kv_we;
  logic [SLOT_W-1:0]     kv_waddr;
  logic [KV_W-1:0]       kv_wdata, kv_rdata;
  logic                  free_we;
  logic [SLOT_W-1:0]     free_waddr, free_raddr;
  logic [SLOT_W-1:0]     free_wdata, free_rdata;
  logic [SLOT_W-1:0]     rd_slot;

  logic                  div_start, div_busy;
  logic [NUM_W-1:0]      div_num, div_quo;

  logic                  in_fire;
  logic [HB_W-1:0]       mask_cur, onehot_cur, key_bkt;
  logic [HB_W+KEY_BITS-1:0] kx, gx;
  logic [KEY_BITS-1:0]   kv_key;
  logic [VALUE_BITS-1:0] kv_val;
  logic                  g_hi, key_hit, grow_go, h_ok, l_ok;
  logic [CNT_W-1:0]      cnt_inc, cnt_dec;
  logic [BITS_W-1:0]     init_eff;
  logic [DENS_W-1:0]     dens_eff;

  assign in_fire    = in_valid && in_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign mask_cur   = ~({HB_W{1'b1}} << cur_bits_r);
  assign onehot_cur = HB_W'(1) << cur_bits_r;
  assign kx         = {{HB_W{1'b0}}, key_r};
  assign key_bkt    = kx[HB_W-1:0] & mask_cur;
  assign kv_key     = kv_rdata[KV_W-1:VALUE_BITS];
  assign kv_val     = kv_rdata[VALUE_BITS-1:0];
  assign gx         = {{HB_W{1'b0}}, kv_key};
  assign g_hi       = |(gx[HB_W-1:0] & onehot_cur);
  assign key_hit    = (kv_key == key_r);
  assign h_ok       = (head_rdata < NIL);
  assign l_ok       = (link_rdata < NIL);
  assign cnt_inc    = count_r + CNT_W'(1);
  assign cnt_dec    = count_r - CNT_W'(1);
  assign grow_go    = (CMP_W'(cnt_inc) >= CMP_W'(thr_r))
                   && (cur_bits_r < BITS_W'(MAX_HASH_BITS));

  always_comb begin
    if (init_cfg_r == '0) begin
      init_eff = BITS_W'(1);
    end else if (32'(init_cfg_r) > MAX_HASH_BITS) begin
      init_eff = BITS_W'(MAX_HASH_BITS);
    end else begin
      init_eff = BITS_W'(init_cfg_r);
    end
    if (dens_cfg_r == '0) begin
      dens_eff = DENS_W'(1);
    end else if (32'(dens_cfg_r) > DENS_MAX) begin
      dens_eff = DENS_W'(DENS_MAX);
    end else begin
      dens_eff = dens_cfg_r;
    end
  end

  assign div_num   = NUM_W'(dens_eff) << cur_bits_r;
  assign div_start = (state_r == S_DIV_GO);

  always_comb begin
    head_raddr = (state_r == S_G_HRD) ? gi_r : key_bkt;
    free_raddr = count_r[SLOT_W-1:0];
    rd_slot    = (state_r == S_HGET || state_r == S_G_HGET) ?
                 head_rdata[SLOT_W-1:0] : link_rdata[SLOT_W-1:0];

    head_we    = 1'b0;
    head_waddr = key_bkt;
    head_wdata = NIL;
    link_we    = 1'b0;
    link_waddr = e_r[SLOT_W-1:0];
    link_wdata = link_rdata;
    kv_we      = 1'b0;
    kv_waddr   = free_rdata;
    kv_wdata   = {key_r, val_r};
    free_we    = 1'b0;
    free_waddr = cnt_dec[SLOT_W-1:0];
    free_wdata = e_r[SLOT_W-1:0];

    case (state_r)
      S_SWEEP: begin
        head_we    = ({1'b0, swp_r} < (SWP_W+1)'(NB));
        head_waddr = swp_r[HB_W-1:0];
        free_we    = ({1'b0, swp_r} < (SWP_W+1)'(POOL_ENTRIES));
        free_waddr = swp_r[SLOT_W-1:0];
        free_wdata = swp_r[SLOT_W-1:0];
      end
      S_HGET: begin
        if (kind_r == KIND_INSERT) begin
          kv_we      = 1'b1;
          link_we    = 1'b1;
          link_waddr = free_rdata;
          link_wdata = head_rdata;
          head_we    = 1'b1;
          head_wdata = PTR_W'(free_rdata);
        end
      end
      S_CMP: begin
        if (key_hit && kind_r == KIND_REMOVE) begin
          free_we = 1'b1;
          if (prev_r == NIL) begin
            head_we    = 1'b1;
            head_wdata = link_rdata;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_r[SLOT_W-1:0];
          end
        end
      end
      S_G_MV: begin
        link_we    = 1'b1;
        link_wdata = g_hi ? gb_r : ga_r;
      end
      S_G_WA: begin
        head_we    = 1'b1;
        head_waddr = gi_r;
        head_wdata = ga_r;
      end
      S_G_WB: begin
        head_we    = 1'b1;
        head_waddr = gi_r | onehot_cur;
        head_wdata = gb_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cfg_r <= INIT_W'(INIT_RESET);
      dens_cfg_r <= DENS_W'(DENS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INIT_BITS: init_cfg_r <= cfg_data[INIT_W-1:0];
        CFG_DENSITY:   dens_cfg_r <= cfg_data;
        default:       dens_cfg_r <= dens_cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      swp_r       <= '0;
      resp_r      <= 1'b0;
      count_r     <= '0;
      cur_bits_r  <= BITS_W'(RST_BITS);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_SWEEP: begin
          swp_r <= swp_r + SWP_W'(1);
          if (swp_r == SWP_W'(SWP_N - 1)) begin
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!div_busy) begin
            thr_r   <= resp_r ? div_quo[THR_W-1:0] : THR_W'(RST_THR);
            state_r <= resp_r ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            kind_r        <= kind_t'(in_kind);
            key_r         <= in_key;
            val_r         <= in_value;
            res_found_r   <= '0;
            res_freed_r   <= '0;
            res_resized_r <= 1'b0;
            if (kind_t'(in_kind) == KIND_CLEAR) begin
              res_status_r  <= ST_OK;
              res_cleared_r <= count_r;
              count_r       <= '0;
              cur_bits_r    <= init_eff;
              swp_r         <= '0;
              resp_r        <= 1'b1;
              state_r       <= S_SWEEP;
            end else if (kind_t'(in_kind) == KIND_INSERT
                         && count_r == CNT_W'(POOL_ENTRIES)) begin
              res_status_r  <= ST_FULL;
              res_cleared_r <= '0;
              state_r       <= S_RESP;
            end else begin
              res_status_r  <= ST_OK;
              res_cleared_r <= '0;
              state_r       <= S_HRD;
            end
          end
        end
        S_HRD: state_r <= S_HGET;
        S_HGET: begin
          prev_r <= NIL;
          e_r    <= head_rdata;
          if (kind_r == KIND_INSERT) begin
            count_r <= cnt_inc;
            if (grow_go) begin
              res_resized_r <= 1'b1;
              gi_r          <= '0;
              state_r       <= S_G_HRD;
            end else begin
              state_r <= S_RESP;
            end
          end else if (h_ok) begin
            state_r <= S_CMP;
          end else begin
            res_status_r <= ST_MISS;
            state_r      <= S_RESP;
          end
        end
        S_CMP: begin
          if (key_hit) begin
            if (kind_r == KIND_LOOKUP) begin
              res_found_r <= kv_val;
            end else begin
              res_freed_r <= kv_val;
              count_r     <= cnt_dec;
            end
            state_r <= S_RESP;
          end else if (l_ok) begin
            prev_r <= e_r;
            e_r    <= link_rdata;
          end else begin
            res_status_r <= ST_MISS;
            state_r      <= S_RESP;
          end
        end
        S_G_HRD: state_r <= S_G_HGET;
        S_G_HGET: begin
          ga_r    <= NIL;
          gb_r    <= NIL;
          e_r     <= head_rdata;
          state_r <= h_ok ? S_G_MV : S_G_WA;
        end
        S_G_MV: begin
          if (g_hi) begin
            gb_r <= e_r;
          end else begin
            ga_r <= e_r;
          end
          e_r <= link_rdata;
          if (!l_ok) begin
            state_r <= S_G_WA;
          end
        end
        S_G_WA: state_r <= S_G_WB;
        S_G_WB: begin
          if (gi_r == mask_cur) begin
            cur_bits_r <= cur_bits_r + BITS_W'(1);
            resp_r     <= 1'b1;
            state_r    <= S_DIV_GO;
          end else begin
            gi_r    <= gi_r + HB_W'(1);
            state_r <= S_G_HRD;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_found_r   <= res_found_r;
            out_freed_r   <= res_freed_r;
            out_resized_r <= res_resized_r;
            out_total_r   <= count_r;
            out_cleared_r <= res_cleared_r;
            resp_r        <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  chtu_ram #(.WIDTH(PTR_W), .DEPTH(NB)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  chtu_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(rd_slot), .rdata(link_rdata)
  );

  chtu_ram #(.WIDTH(KV_W), .DEPTH(POOL_ENTRIES)) u_kv (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(kv_wdata),
    .raddr(rd_slot), .rdata(kv_rdata)
  );

  chtu_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_ENTRIES)) u_free (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_raddr), .rdata(free_rdata)
  );

  chtu_div #(.NUM_W(NUM_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .busy(div_busy), .quo(div_quo)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_value   = out_found_r;
  assign out_freed_value   = out_freed_r;
  assign out_resized       = out_resized_r;
  assign out_entry_total   = out_total_r;
  assign out_cleared_count = out_cleared_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(POOL_ENTRIES))
    else $error("entry count above pool size");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_bits_r >= BITS_W'(1) && cur_bits_r <= BITS_W'(MAX_HASH_BITS))
    else $error("hash bits out of range");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second word taken while busy");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HGET && kind_r == KIND_INSERT) |-> count_r < CNT_W'(POOL_ENTRIES))
    else $error("insert into full pool");
`endif

endmodule

/* sim/tb.sv */
// Self-checking bench for chained_hash_table_unit: a scoreboard class mirrors the
// chained table and checks each result word. Depends on rtl/chtu_pkg.sv and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chtu_pkg::*;

  localparam int MAXB  = 10;
  localparam int POOL  = 1024;
  localparam int NIL   = POOL;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [31:0] freed_value;
    logic        resized;
    logic [10:0] entry_total;
    logic [10:0] cleared_count;
  } table_reply_t;

  class hash_table_scoreboard;
    int unsigned head[POOL];
    int unsigned link[POOL];
    logic [63:0] keys[POOL];
    logic [31:0] vals[POOL];
    int unsigned free_list[POOL];
    int unsigned count, bits, threshold;
    logic [3:0] init_reg;
    logic [6:0] dens_reg;
    table_reply_t replies[$];
    int errors;

    function new();
      init_reg = 4'(INIT_RESET);
      dens_reg = 7'(DENS_RESET);
      errors = 0;
      empty_table();
    endfunction

    function int unsigned grow_point(int unsigned b);
      int unsigned d;
      d = 32'(dens_reg);
      if (d < 1) d = 1;
      if (d > DENS_MAX) d = DENS_MAX;
      return ((1 << b) * d) / 100;
    endfunction

    function void empty_table();
      int unsigned b;
      b = 32'(init_reg);
      if (b < 1) b = 1;
      if (b > MAXB) b = MAXB;
      foreach (head[i]) head[i] = NIL;
      foreach (free_list[i]) free_list[i] = i;
      count = 0;
      bits = b;
      threshold = grow_point(b);
    endfunction

    function int unsigned bucket(logic [63:0] k);
      return 32'(k & ((64'd1 << bits) - 1));
    endfunction

    function void double_table();
      int unsigned old_head[POOL];
      int unsigned old_cap, e, nxt, b;
      old_cap = 1 << bits;
      old_head = head;
      bits++;
      threshold = grow_point(bits);
      foreach (head[i]) head[i] = NIL;
      for (int i = 0; i < old_cap; i++) begin
        e = old_head[i];
        while (e < POOL) begin
          nxt = link[e];
          b = bucket(keys[e]);
          link[e] = head[b];
          head[b] = e;
          e = nxt;
        end
      end
    endfunction

    function void write_reg(logic idx, logic [6:0] data);
      if (idx == CFG_INIT_BITS) init_reg = data[3:0];
      else dens_reg = data;
    endfunction

    function void note_request(kind_t kind, logic [63:0] k, logic [31:0] v);
      table_reply_t r;
      int unsigned e, prev, b, slot;
      r = '0;
      r.status = ST_OK;
      case (kind)
        KIND_LOOKUP: begin
          e = head[bucket(k)];
          while (e < POOL && keys[e] != k) e = link[e];
          if (e < POOL) r.found_value = vals[e];
          else r.status = ST_MISS;
        end
        KIND_INSERT: begin
          if (count >= POOL) begin
            r.status = ST_FULL;
          end else begin
            slot = free_list[count];
            b = bucket(k);
            keys[slot] = k;
            vals[slot] = v;
            link[slot] = head[b];
            head[b] = slot;
            count++;
            if (count >= threshold && bits < MAXB) begin
              double_table();
              r.resized = 1'b1;
            end
          end
        end
        KIND_REMOVE: begin
          b = bucket(k);
          prev = NIL;
          e = head[b];
          while (e < POOL && keys[e] != k) begin
            prev = e;
            e = link[e];
          end
          if (e < POOL) begin
            if (prev == NIL) head[b] = link[e];
            else link[prev] = link[e];
            r.freed_value = vals[e];
            if (count > 0) count--;
            free_list[count] = e;
          end else begin
            r.status = ST_MISS;
          end
        end
        default: begin
          r.cleared_count = 11'(count);
          empty_table();
        end
      endcase
      r.entry_total = 11'(count);
      replies.push_back(r);
    endfunction

    function void check_response(table_reply_t got);
      table_reply_t want;
      if (replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = replies.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [63:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_found_value, out_freed_value;
  logic        out_resized;
  logic [10:0] out_entry_total, out_cleared_count;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;

  hash_table_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit quiet = 0;
  logic [63:0] key_set[24];

  chained_hash_table_unit u_dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_response({out_status, out_found_value, out_freed_value, out_resized,
                         out_entry_total, out_cleared_count});
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 9) < 7) begin
      out_ready <= 1'b1;
    end else begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end
  end

  task automatic send_word(kind_t kind, logic [63:0] k, logic [31:0] v);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 9) >= 6)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key <= k;
    in_value <= v;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_request(kind, k, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.replies.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_set[$urandom_range(0, 23)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) send_word(KIND_INSERT, pick_key(), $urandom);
    else if (r < 70) send_word(KIND_LOOKUP, pick_key(), $urandom);
    else if (r < 97) send_word(KIND_REMOVE, pick_key(), $urandom);
    else send_word(KIND_CLEAR, pick_key(), $urandom);
  endtask

  initial begin
    logic [6:0] init_pick[5];
    logic [6:0] dens_pick[5];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_word(KIND_LOOKUP, 64'd0, 32'd0);
    send_word(KIND_INSERT, 64'd0, 32'h1111_0000);
    send_word(KIND_INSERT, '1, '1);
    send_word(KIND_INSERT, 64'd0, 32'h2222_0000);
    send_word(KIND_LOOKUP, 64'd0, 32'd0);
    send_word(KIND_REMOVE, 64'd0, 32'd0);
    send_word(KIND_LOOKUP, 64'd0, 32'd0);
    send_word(KIND_REMOVE, '1, 32'd0);
    send_word(KIND_REMOVE, 64'h8000_0000_0000_0000, 32'd0);
    for (int i = 0; i < 12; i++) send_word(KIND_INSERT, {$urandom, 28'd0, 4'(i)}, $urandom);
    send_word(KIND_LOOKUP, 64'd5, 32'd0);
    send_word(KIND_CLEAR, 64'd0, 32'd0);
    send_word(KIND_CLEAR, 64'd0, 32'd0);
    drain();

    init_pick = '{7'd0, 7'd1, 7'd10, 7'd15, 7'd3};
    dens_pick = '{7'd0, 7'd1, 7'd100, 7'd127, 7'd60};
    for (int p = 0; p < 8; p++) begin
      write_cfg(CFG_INIT_BITS, (p < 5) ? init_pick[p] : 7'($urandom_range(0, 127)));
      write_cfg(CFG_DENSITY, (p < 5) ? dens_pick[4 - p] : 7'($urandom_range(0, 127)));
      quiet = (p == 2);
      foreach (key_set[i])
        key_set[i] = (i < 12) ? {$urandom, $urandom} : {$urandom, 28'd0, 4'($urandom_range(0, 3))};
      if (p % 2 == 0) send_word(KIND_CLEAR, {$urandom, $urandom}, $urandom);
      for (int i = 0; i < 8; i++) begin
        random_word();
        if (p == 4 && i == 4) drain();
      end
      drain();
    end
    quiet = 0;

    write_cfg(CFG_INIT_BITS, 7'd10);
    write_cfg(CFG_DENSITY, 7'd100);
    send_word(KIND_CLEAR, '0, '0);
    for (int i = 0; i < POOL + 2; i++) send_word(KIND_INSERT, {$urandom, $urandom}, $urandom);
    send_word(KIND_REMOVE, pick_key(), '0);
    send_word(KIND_INSERT, {$urandom, $urandom}, $urandom);
    send_word(KIND_CLEAR, '0, '0);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.replies.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/chtu_pkg.sv
rtl/chtu_ram.sv
rtl/chtu_div.sv
rtl/chained_hash_table_unit.sv
sim/tb.sv
